### sv/nxpc_pkg.sv
// Shared types, codes and helper functions for the next-PC predictor.
// No dependencies; every other file imports this package.
package nxpc_pkg;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_PREDICT = 2'd1,
    OP_RESP    = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_NEXT    = 2'd0,
    KIND_LOAD    = 2'd1,
    KIND_LOOP    = 2'd2,
    KIND_ILLEGAL = 2'd3
  } kind_e;

  localparam int unsigned NumRegs     = 16;
  localparam logic [4:0]  StatusIndex = 5'd16;
  localparam int unsigned ThumbBit    = 5;
  localparam int unsigned CarryBit    = 29;

  typedef struct packed {
    logic        valid;     // item produces a result
    kind_e       kind;
    logic [31:0] target;
    logic        thumb;
    logic        set_pend;  // load request issued, wait for response
    logic        pend_thumb;
  } res_t;

  function automatic logic cond_true(input logic [3:0] cond, input logic [31:0] st);
    logic n, z, c, v, r;
    n = st[31];
    z = st[30];
    c = st[29];
    v = st[28];
    unique case (cond)
      4'd0:    r = z;
      4'd1:    r = !z;
      4'd2:    r = c;
      4'd3:    r = !c;
      4'd4:    r = n;
      4'd5:    r = !n;
      4'd6:    r = v;
      4'd7:    r = !v;
      4'd8:    r = c && !z;
      4'd9:    r = !c || z;
      4'd10:   r = (n == v);
      4'd11:   r = (n != v);
      4'd12:   r = !z && (n == v);
      4'd13:   r = z || (n != v);
      default: r = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] addr_mask(input logic [31:0] v, input logic thumb,
                                            input logic m32);
    logic [31:0] m;
    m = m32 ? 32'hffff_ffff : 32'h03ff_ffff;
    m[0] = 1'b0;
    if (!thumb) m[1] = 1'b0;
    return v & m;
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] a);
    logic [63:0] t;
    t = {v, v} >> a;
    return t[31:0];
  endfunction

  function automatic logic [4:0] popcnt16(input logic [15:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 16; i++) n = n + {4'd0, v[i]};
    return n;
  endfunction

endpackage

### sv/nxpc_shift.sv
// Barrel shifter for the ARM shifted register operand (immediate or register amount).
// Depends on nxpc_pkg.
module nxpc_shift (
  input  logic [31:0] inst_i,
  input  logic [31:0] rm_val_i,
  input  logic [7:0]  rs_amt_i,
  input  logic        carry_i,
  output logic [31:0] op_o
);
  import nxpc_pkg::*;

  logic [1:0] sh_type;
  logic [4:0] imm_amt;
  logic       big;

  assign sh_type = inst_i[6:5];
  assign imm_amt = inst_i[11:7];
  assign big     = rs_amt_i[7:5] != 3'd0;

  always_comb begin
    op_o = rm_val_i;
    if (inst_i[4]) begin
      if (rs_amt_i != 8'd0) begin
        unique case (sh_type)
          2'd0: op_o = big ? 32'd0 : rm_val_i << rs_amt_i[4:0];
          2'd1: op_o = big ? 32'd0 : rm_val_i >> rs_amt_i[4:0];
          2'd2: op_o = big ? {32{rm_val_i[31]}} : 32'($signed(rm_val_i) >>> rs_amt_i[4:0]);
          default: op_o = ror32(rm_val_i, rs_amt_i[4:0]);
        endcase
      end
    end else begin
      unique case (sh_type)
        2'd0: op_o = rm_val_i << imm_amt;
        2'd1: op_o = (imm_amt == 5'd0) ? 32'd0 : rm_val_i >> imm_amt;
        2'd2: op_o = (imm_amt == 5'd0) ? {32{rm_val_i[31]}}
                                       : 32'($signed(rm_val_i) >>> imm_amt);
        // ROR #0 encodes RRX
        default: op_o = (imm_amt == 5'd0) ? {carry_i, rm_val_i[31:1]}
                                          : ror32(rm_val_i, imm_amt);
      endcase
    end
  end

endmodule

### sv/nxpc_core.sv
// Decode and target computation for one registered item (ARM, Thumb, load response).
// Depends on nxpc_pkg and nxpc_shift.
module nxpc_core (
  input  nxpc_pkg::opcode_e opcode_i,
  input  logic [31:0]       value_i,
  input  logic [31:0]       inst_i,
  input  logic [31:0]       pc_i,
  input  logic [31:0]       regs_i [16],
  input  logic [31:0]       status_i,
  input  logic              mode_32bit_i,
  input  logic              pend_i,
  input  logic [31:0]       pend_pc_i,
  input  logic              pend_thumb_i,
  output nxpc_pkg::res_t    res_o
);
  import nxpc_pkg::*;

  logic [31:0] pc2, pc4, pc8, pc12;
  logic [31:0] rn_val, rm_val, rm_sh_val, rs_val, tbx_val, op2_sh;
  logic [31:0] op1, op2, alu, dp_t, ld_base, ld_off, lm_off, br_t, fin_v;
  logic        carry;
  logic [15:0] i1, i2;
  logic [31:0] t_off, bx_v;

  assign pc2   = pc_i + 32'd2;
  assign pc4   = pc_i + 32'd4;
  assign pc8   = pc_i + 32'd8;
  assign pc12  = pc_i + 32'd12;
  assign carry = status_i[CarryBit];
  assign i1    = inst_i[15:0];
  assign i2    = inst_i[31:16];

  // r15 reads as the pipelined pc
  assign rn_val    = (inst_i[19:16] == 4'hf) ? pc8 : regs_i[inst_i[19:16]];
  assign rs_val    = (inst_i[11:8] == 4'hf) ? pc8 : regs_i[inst_i[11:8]];
  assign rm_val    = (inst_i[3:0] == 4'hf) ? pc8 : regs_i[inst_i[3:0]];
  assign rm_sh_val = (inst_i[3:0] == 4'hf) ? (inst_i[4] ? pc12 : pc8) : regs_i[inst_i[3:0]];
  assign tbx_val   = (i1[6:3] == 4'hf) ? pc4 : regs_i[i1[6:3]];

  nxpc_shift u_shift (
    .inst_i   (inst_i),
    .rm_val_i (rm_sh_val),
    .rs_amt_i (rs_val[7:0]),
    .carry_i  (carry),
    .op_o     (op2_sh)
  );

  assign op1 = rn_val;
  assign op2 = inst_i[25] ? ror32({24'd0, inst_i[7:0]}, {inst_i[11:8], 1'b0}) : op2_sh;

  always_comb begin
    unique case (inst_i[24:21])
      4'd0:    alu = op1 & op2;
      4'd1:    alu = op1 ^ op2;
      4'd2:    alu = op1 - op2;
      4'd3:    alu = op2 - op1;
      4'd4:    alu = op1 + op2;
      4'd5:    alu = op1 + op2 + {31'd0, carry};
      4'd6:    alu = op1 - op2 + {31'd0, carry};
      4'd7:    alu = op2 - op1 + {31'd0, carry};
      4'd12:   alu = op1 | op2;
      4'd13:   alu = op2;
      4'd14:   alu = op1 & ~op2;
      4'd15:   alu = ~op2;
      default: alu = pc4;
    endcase
  end

  assign dp_t    = addr_mask(alu, 1'b0, mode_32bit_i);
  assign ld_off  = inst_i[25] ? op2_sh : {20'd0, inst_i[11:0]};
  assign ld_base = !inst_i[24] ? rn_val : (inst_i[23] ? rn_val + ld_off : rn_val - ld_off);
  assign br_t    = addr_mask(pc8 + {{6{inst_i[23]}}, inst_i[23:0], 2'b00}, 1'b0,
                             mode_32bit_i);
  assign fin_v   = addr_mask(value_i, pend_thumb_i, mode_32bit_i);
  assign bx_v    = status_i[ThumbBit] ? tbx_val : rm_val;

  always_comb begin
    lm_off = 32'd0;
    if (inst_i[23]) begin
      lm_off = {25'd0, popcnt16({1'b0, inst_i[14:0]}), 2'b00};
      if (inst_i[24]) lm_off = lm_off + 32'd4;
    end else if (inst_i[24]) begin
      lm_off = 32'hffff_fffc;
    end
  end

  always_comb begin
    t_off = pc2;
    unique case (1'b1)
      i1[15:12] == 4'hd: t_off = pc4 + {{23{i1[7]}}, i1[7:0], 1'b0};
      i1[15:11] == 5'b11100: t_off = pc4 + {{20{i1[10]}}, i1[10:0], 1'b0};
      default: t_off = pc4 + {{9{i1[10]}}, i1[10:0], 12'd0} + {20'd0, i2[10:0], 1'b0};
    endcase
  end

  always_comb begin
    res_o = '{valid: 1'b0, kind: KIND_NEXT, target: 32'd0, thumb: 1'b0,
              set_pend: 1'b0, pend_thumb: 1'b0};
    unique case (opcode_i)
      OP_RESP: begin
        if (pend_i) begin
          res_o.valid = 1'b1;
          if (fin_v == pend_pc_i) res_o.kind = KIND_LOOP;
          else begin
            res_o.target = fin_v;
            res_o.thumb  = pend_thumb_i;
          end
        end
      end
      OP_PREDICT: begin
        res_o.valid = 1'b1;
        if (status_i[ThumbBit]) begin
          res_o.thumb  = 1'b1;
          res_o.target = pc2;
          priority if (i1[15:8] == 8'hbd) begin
            res_o.kind       = KIND_LOAD;
            res_o.thumb      = 1'b0;
            res_o.set_pend   = 1'b1;
            res_o.pend_thumb = 1'b1;
            res_o.target     = regs_i[13] + {25'd0, popcnt16({8'd0, i1[7:0]}), 2'b00};
          end else if (i1[15:12] == 4'hd) begin
            if (i1[11:8] != 4'hf && cond_true(i1[11:8], status_i))
              res_o.target = addr_mask(t_off, 1'b1, mode_32bit_i);
          end else if (i1[15:12] == 4'he && !i1[11]) begin
            res_o.target = addr_mask(t_off, 1'b1, mode_32bit_i);
          end else if (i1[15:11] == 5'b11110) begin
            res_o.target = addr_mask(t_off, 1'b1, mode_32bit_i);
          end else if (i1[15:7] == 9'b010001110) begin
            res_o.thumb  = bx_v[0];
            res_o.target = addr_mask({bx_v[31:1], 1'b0}, bx_v[0], mode_32bit_i);
          end else begin
            res_o.target = pc2;
          end
        end else begin
          res_o.target = pc4;
          priority if (!cond_true(inst_i[31:28], status_i)) begin
            res_o.target = pc4;
          end else if (inst_i[27:4] == 24'h12fff1) begin
            res_o.thumb  = bx_v[0];
            res_o.target = addr_mask({bx_v[31:1], 1'b0}, bx_v[0], mode_32bit_i);
          end else if (inst_i[27:26] == 2'b00) begin
            if (inst_i[15:12] == 4'hf) begin
              if (inst_i[25:22] == 4'd0 && inst_i[7:4] == 4'd9) begin
                res_o.kind = KIND_ILLEGAL;
                res_o.target = 32'd0;
              end else if (dp_t == pc_i) begin
                res_o.kind = KIND_LOOP;
                res_o.target = 32'd0;
              end else res_o.target = dp_t;
            end
          end else if (inst_i[27:26] == 2'b01) begin
            if (inst_i[20] && inst_i[15:12] == 4'hf) begin
              res_o.target = 32'd0;
              if (inst_i[22]) res_o.kind = KIND_ILLEGAL;
              else begin
                res_o.kind     = KIND_LOAD;
                res_o.set_pend = 1'b1;
                res_o.target   = ld_base;
              end
            end
          end else if (inst_i[27:25] == 3'b100) begin
            if (inst_i[20] && inst_i[15]) begin
              res_o.kind     = KIND_LOAD;
              res_o.set_pend = 1'b1;
              res_o.target   = rn_val + lm_off;
            end
          end else if (inst_i[27:25] == 3'b101) begin
            if (br_t == pc_i) begin
              res_o.kind = KIND_LOOP;
              res_o.target = 32'd0;
            end else res_o.target = br_t;
          end else begin
            res_o.target = pc4;
          end
        end
      end
      default: res_o.valid = 1'b0;
    endcase
  end

endmodule

### sv/arm_thumb_next_pc_predictor.sv
// Top level of the ARM/Thumb next-PC predictor: input stage, state, result register.
// Depends on nxpc_pkg and nxpc_core.
//
// Takes one item per clock cycle while the output is not stalled. A result is on the
// outputs once its item has passed the input register and then the result register,
// with the decode, shifter and adder of nxpc_core between them. Register and status
// writes take effect for the item accepted right after them. A load to pc returns a
// read request; the later response item completes it with the loaded target.
module arm_thumb_next_pc_predictor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [4:0]  reg_index_i,
  input  logic [31:0] value_i,
  input  logic [31:0] instr_word_i,
  input  logic [31:0] pc_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [31:0] target_o,
  output logic        target_thumb_o
);
  import nxpc_pkg::*;

  logic        s1_valid_q;
  opcode_e     s1_op_q;
  logic [4:0]  s1_idx_q;
  logic [31:0] s1_value_q, s1_inst_q, s1_pc_q;
  logic [31:0] regs_q [NumRegs];
  logic [31:0] status_q;
  logic        mode_q, pend_q, pend_thumb_q;
  logic [31:0] pend_pc_q;
  logic        out_valid_q, out_thumb_q;
  kind_e       out_kind_q;
  logic [31:0] out_target_q;
  logic        advance;
  res_t        res;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  nxpc_core u_core (
    .opcode_i     (s1_op_q),
    .value_i      (s1_value_q),
    .inst_i       (s1_inst_q),
    .pc_i         (s1_pc_q),
    .regs_i       (regs_q),
    .status_i     (status_q),
    .mode_32bit_i (mode_q),
    .pend_i       (pend_q),
    .pend_pc_i    (pend_pc_q),
    .pend_thumb_i (pend_thumb_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      mode_q       <= 1'b1;
      status_q     <= '0;
      pend_q       <= 1'b0;
      pend_pc_q    <= '0;
      pend_thumb_q <= 1'b0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (advance && res.valid) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (advance) begin
        if (s1_op_q == OP_WRITE && s1_idx_q == StatusIndex) status_q <= s1_value_q;
        // a predict drops any pending load, a response ends it
        if (s1_op_q == OP_PREDICT || s1_op_q == OP_RESP) pend_q <= res.set_pend;
        if (res.set_pend) begin
          pend_pc_q    <= s1_pc_q;
          pend_thumb_q <= res.pend_thumb;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q    <= opcode_e'(opcode_i);
      s1_idx_q   <= reg_index_i;
      s1_value_q <= value_i;
      s1_inst_q  <= instr_word_i;
      s1_pc_q    <= pc_i;
    end
    if (advance && s1_op_q == OP_WRITE && !s1_idx_q[4]) regs_q[s1_idx_q[3:0]] <= s1_value_q;
    if (advance && res.valid) begin
      out_kind_q   <= res.kind;
      out_target_q <= res.target;
      out_thumb_q  <= res.thumb;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_kind_q;
  assign target_o       = out_target_q;
  assign target_thumb_o = out_thumb_q;

endmodule

### sv/nxpc_checker.sv
// Port-level checks for the next-PC predictor, bound to the top level.
// Depends on nxpc_pkg and arm_thumb_next_pc_predictor.
module nxpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  result_kind_o,
  input logic [31:0] target_o,
  input logic        target_thumb_o
);
  import nxpc_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(target_o))
    else $error("stalled result changed");

  a_loop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == KIND_LOOP || result_kind_o == KIND_ILLEGAL)
      |-> target_o == 32'd0 && !target_thumb_o)
    else $error("error result carries a target");

  a_load_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_LOAD |-> !target_thumb_o)
    else $error("read request flagged thumb");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without an item two cycles earlier");

endmodule

bind arm_thumb_next_pc_predictor nxpc_checker u_nxpc_checker (.*);
